@@ rtl/core/hrh_pkg.sv @@
// Shared types and constants for the homopolymer run histogram.
// Used by hrh_hist_bank and homopolymer_run_histogram_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hrh_pkg;

   localparam int ACT_W       = 2;
   localparam int SYM_W       = 8;
   localparam int QLEN_W      = 7;
   localparam int CSR_W       = 7;
   localparam int OUT_W       = 32;
   localparam int NUM_SYMBOLS = 256;

   localparam logic [ACT_W-1:0] ACT_SYMBOL = 2'd0;
   localparam logic [ACT_W-1:0] ACT_END    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

   localparam logic [CSR_W-1:0] MIN_RUN_RESET = 7'd4;

   typedef struct packed {
      logic valid;
      logic is_read;
      logic force_zero;
   } hrh_op_type;

   typedef struct packed {
      logic clearing;
      logic read_pending;
   } hrh_status_type;

endpackage

`default_nettype wire

@@ rtl/core/hrh_hist_bank.sv @@
// Histogram memory with post-reset clearing pass, read-modify-write stage and forwarding.
// Depends on hrh_pkg for the operation and status structs.
`timescale 1ns / 1ps
`default_nettype none

module hrh_hist_bank #(
   parameter int DEPTH       = 16384,
   parameter int ADDR_W      = 14,
   parameter int COUNT_WIDTH = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  hrh_pkg::hrh_op_type          op,
   input  wire  [ADDR_W-1:0]            op_addr,
   output hrh_pkg::hrh_status_type      status,
   output logic                         res_valid,
   output logic [hrh_pkg::OUT_W-1:0]    res_count
);

   localparam int EXT_W = (COUNT_WIDTH > hrh_pkg::OUT_W) ? COUNT_WIDTH : hrh_pkg::OUT_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [COUNT_WIDTH-1:0] mem [DEPTH];
   logic [COUNT_WIDTH-1:0] rd_ff;

   logic                   clearing_ff, clearing_in;
   logic [ADDR_W-1:0]      clr_addr_ff, clr_addr_in;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_read_ff;
   logic                   s1_zero_ff;
   logic [ADDR_W-1:0]      s1_addr_ff;

   logic                   fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0]      fwd_addr_ff;
   logic [COUNT_WIDTH-1:0] fwd_data_ff;

   logic [COUNT_WIDTH-1:0] cur_count;
   logic [COUNT_WIDTH-1:0] inc_count;
   logic [EXT_W-1:0]       cur_ext;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic                   s1_write;

   always_comb begin
      cur_count = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : rd_ff;
      inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_WIDTH'(1);
      cur_ext   = EXT_W'(cur_count);
      s1_write  = s1_valid_ff && !s1_read_ff;

      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = s1_write;
         wr_addr = s1_addr_ff;
         wr_data = inc_count;
      end

      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end

      s1_valid_in  = op.valid;
      fwd_valid_in = s1_write && !clearing_ff;

      res_valid = s1_valid_ff && s1_read_ff;
      if (s1_zero_ff) begin
         res_count = '0;
      end else if (cur_ext > EXT_W'({hrh_pkg::OUT_W{1'b1}})) begin
         res_count = '1;
      end else begin
         res_count = cur_ext[hrh_pkg::OUT_W-1:0];
      end

      status.clearing     = clearing_ff;
      status.read_pending = s1_valid_ff && s1_read_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[op_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_read_ff  <= op.is_read;
      s1_zero_ff  <= op.force_zero;
      s1_addr_ff  <= op_addr;
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= inc_count;
   end

   a_no_op_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !op.valid)
      else $error("Operation issued during the clearing pass.");

   a_result_follows_read: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> $past(op.valid && op.is_read))
      else $error("Result without a preceding read transaction.");

   a_clear_ends_once: assert property (@(posedge clock) disable iff (reset)
      $fell(clearing_ff) |-> $past(clr_addr_ff == ADDR_W'(DEPTH - 1)))
      else $error("Clearing pass ended before the last entry.");

   a_forward_only_after_update: assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> $past(s1_valid_ff && !s1_read_ff))
      else $error("Forwarding register valid without an update.");

endmodule

`default_nettype wire

@@ rtl/core/homopolymer_run_histogram_top.sv @@
// Throughput: one transaction per cycle while req_stall is low; a read's count is taken into
// the bank's s1 stage and then registered in the output queue. Symbol and end-of-sequence
// transactions produce no result; the two-entry output queue lets input continue while a
// count waits. After reset the histogram is cleared one entry per cycle, and req_stall is
// high while it clears; csr writes are taken at any time. Reset sets min_run to 4 and ends any active run.
// Depends on hrh_pkg and hrh_hist_bank.
`timescale 1ns / 1ps
`default_nettype none

module homopolymer_run_histogram_top #(
   parameter int MAX_RUN     = 64,
   parameter int COUNT_WIDTH = 32
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire  [hrh_pkg::ACT_W-1:0]      req_action,
   input  wire  [hrh_pkg::SYM_W-1:0]      req_symbol,
   input  wire  [hrh_pkg::QLEN_W-1:0]     req_query_length,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [hrh_pkg::OUT_W-1:0]      rsp_bin_count,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire  [hrh_pkg::CSR_W-1:0]      csr_data
);

   localparam int DEPTH  = hrh_pkg::NUM_SYMBOLS * MAX_RUN;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int RUN_W  = $clog2(MAX_RUN + 1);
   localparam int CMP_W  = (RUN_W > hrh_pkg::CSR_W) ? RUN_W : hrh_pkg::CSR_W;
   localparam logic [ADDR_W-1:0] MAX_RUN_A = ADDR_W'(MAX_RUN);

   logic [hrh_pkg::CSR_W-1:0] min_run_ff;
   logic [hrh_pkg::SYM_W-1:0] cur_sym_ff, cur_sym_in;
   logic [RUN_W-1:0]          run_len_ff, run_len_in;

   logic [1:0]                occ_ff, occ_in;
   logic [hrh_pkg::OUT_W-1:0] q0_ff, q0_in, q1_ff, q1_in;

   hrh_pkg::hrh_op_type       op;
   hrh_pkg::hrh_status_type   status;
   logic [ADDR_W-1:0]         op_addr;
   logic                      res_valid;
   logic [hrh_pkg::OUT_W-1:0] res_count;

   logic                      accept, pop, same_run, close_hit;
   logic [2:0]                room_used;
   logic [ADDR_W-1:0]         close_addr, query_addr;

   always_comb begin
      pop       = rsp_valid && !rsp_stall;
      room_used = 3'(occ_ff) - 3'(pop) + 3'(status.read_pending);
      req_stall = status.clearing || (room_used >= 3'd2);
      accept    = req_valid && !req_stall;
      csr_ready = 1'b1;

      same_run  = (run_len_ff != '0) && (req_symbol == cur_sym_ff);
      close_hit = (run_len_ff != '0) && (CMP_W'(run_len_ff) >= CMP_W'(min_run_ff));
      close_addr = ADDR_W'(cur_sym_ff) * MAX_RUN_A + ADDR_W'(run_len_ff) - ADDR_W'(1);
      query_addr = ADDR_W'(req_symbol) * MAX_RUN_A + ADDR_W'(req_query_length)
                   - ADDR_W'(1);

      cur_sym_in    = cur_sym_ff;
      run_len_in    = run_len_ff;
      op.valid      = 1'b0;
      op.is_read    = 1'b0;
      op.force_zero = (req_query_length == '0) ||
                      (CMP_W'(req_query_length) > CMP_W'(MAX_RUN));
      op_addr       = close_addr;

      case (req_action)
         hrh_pkg::ACT_SYMBOL: begin
            if (same_run) begin
               if (run_len_ff < RUN_W'(MAX_RUN)) begin
                  run_len_in = run_len_ff + RUN_W'(1);
               end
            end else begin
               op.valid   = accept && close_hit;
               cur_sym_in = req_symbol;
               run_len_in = RUN_W'(1);
            end
         end
         hrh_pkg::ACT_END: begin
            op.valid   = accept && close_hit;
            run_len_in = '0;
         end
         hrh_pkg::ACT_READ: begin
            op.valid   = accept;
            op.is_read = 1'b1;
            op_addr    = query_addr;
         end
         default: begin
         end
      endcase

      occ_in = occ_ff;
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      if (pop && res_valid) begin
         if (occ_ff == 2'd2) begin
            q0_in = q1_ff;
            q1_in = res_count;
         end else begin
            q0_in = res_count;
         end
      end else if (pop) begin
         q0_in  = q1_ff;
         occ_in = occ_ff - 2'd1;
      end else if (res_valid) begin
         if (occ_ff == 2'd0) begin
            q0_in = res_count;
         end else begin
            q1_in = res_count;
         end
         occ_in = occ_ff + 2'd1;
      end

      rsp_valid     = (occ_ff != 2'd0);
      rsp_bin_count = q0_ff;
   end

   hrh_hist_bank #(
      .DEPTH       (DEPTH),
      .ADDR_W      (ADDR_W),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_bank (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .op_addr   (op_addr),
      .status    (status),
      .res_valid (res_valid),
      .res_count (res_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         min_run_ff <= hrh_pkg::MIN_RUN_RESET;
         cur_sym_ff <= '0;
         run_len_ff <= '0;
         occ_ff     <= 2'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            min_run_ff <= csr_data;
         end
         if (accept) begin
            cur_sym_ff <= cur_sym_in;
            run_len_ff <= run_len_in;
         end
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(res_valid && !pop && (occ_ff == 2'd2)))
      else $error("Result arrived with the output queue full.");

   a_run_len_bounded: assert property (@(posedge clock) disable iff (reset)
      run_len_ff <= RUN_W'(MAX_RUN))
      else $error("Run length exceeds its saturation value.");

   a_end_clears_run: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == hrh_pkg::ACT_END)) |=> (run_len_ff == '0))
      else $error("End-of-sequence transaction left a run active.");

endmodule

`default_nettype wire

@@ test/homopolymer_run_histogram_top_tb.sv @@
// Self-checking testbench for homopolymer_run_histogram_top: a queue-fed driver, a checking
// monitor and a histogram predictor, run over several min_run settings and idle patterns.
// Depends on hrh_pkg and the homopolymer_run_histogram_top RTL.
`timescale 1ns / 1ps

module homopolymer_run_histogram_top_tb;

   localparam int ACT_W           = hrh_pkg::ACT_W;
   localparam int SYM_W           = hrh_pkg::SYM_W;
   localparam int QLEN_W          = hrh_pkg::QLEN_W;
   localparam int CSR_W           = hrh_pkg::CSR_W;
   localparam int OUT_W           = hrh_pkg::OUT_W;
   localparam int MAX_RUN         = 64;
   localparam int COUNT_WIDTH     = 32;
   localparam int NUM_BINS        = hrh_pkg::NUM_SYMBOLS * MAX_RUN;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 130;
   localparam int SETTLE_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT  = 4 * NUM_BINS;
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [SYM_W-1:0]  symbol;
      logic [QLEN_W-1:0] query_length;
   } hist_req_type;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic [ACT_W-1:0]  req_action       = '0;
   logic [SYM_W-1:0]  req_symbol       = '0;
   logic [QLEN_W-1:0] req_query_length = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic [OUT_W-1:0]  rsp_bin_count;
   logic              csr_valid        = 1'b0;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_data         = '0;

   hist_req_type      pending_reqs[$];
   logic [OUT_W-1:0]  expected_counts[$];
   hist_req_type      req_in_flight;
   int unsigned       send_idle_pct    = 0;
   int unsigned       recv_stall_pct   = 0;
   int unsigned       mismatch_count   = 0;
   int unsigned       reqs_accepted    = 0;
   int unsigned       counts_checked   = 0;
   int unsigned       idle_cycles      = 0;

   // Predicted block state.
   logic [COUNT_WIDTH-1:0] hist_model[NUM_BINS];
   logic [SYM_W-1:0]       model_symbol;
   int unsigned            model_run_len;
   logic [CSR_W-1:0]       model_min_run;

   homopolymer_run_histogram_top #(
      .MAX_RUN     (MAX_RUN),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_symbol       (req_symbol),
      .req_query_length (req_query_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bin_count    (rsp_bin_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic close_model_run();
      int unsigned idx;
      if (model_run_len != 0 && model_run_len >= model_min_run) begin
         idx = model_symbol * MAX_RUN + model_run_len - 1;
         if (hist_model[idx] != '1) begin
            hist_model[idx]++;
         end
      end
      model_run_len = 0;
   endtask

   task automatic track_histogram(input hist_req_type rq);
      logic [OUT_W-1:0] count;
      case (rq.action)
         hrh_pkg::ACT_SYMBOL: begin
            if (model_run_len != 0 && rq.symbol == model_symbol) begin
               if (model_run_len < MAX_RUN) begin
                  model_run_len++;
               end
            end else begin
               close_model_run();
               model_symbol  = rq.symbol;
               model_run_len = 1;
            end
         end
         hrh_pkg::ACT_END: begin
            close_model_run();
         end
         hrh_pkg::ACT_READ: begin
            count = '0;
            if (rq.query_length >= 1 && rq.query_length <= MAX_RUN) begin
               count = OUT_W'(hist_model[rq.symbol * MAX_RUN + rq.query_length - 1]);
            end
            expected_counts.push_back(count);
         end
         default: begin
         end
      endcase
   endtask

   // Driver: holds a transaction while stalled, then takes the next pending one or idles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            track_histogram(req_in_flight);
            reqs_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_in_flight     = pending_reqs.pop_front();
               req_action       <= req_in_flight.action;
               req_symbol       <= req_in_flight.symbol;
               req_query_length <= req_in_flight.query_length;
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each accepted count with the oldest expected one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_counts.size() == 0) begin
               report_mismatch($sformatf("unexpected result, bin_count %0d", rsp_bin_count));
            end else begin
               if (rsp_bin_count !== expected_counts[0]) begin
                  report_mismatch($sformatf("bin_count %0d, expected %0d",
                                            rsp_bin_count, expected_counts[0]));
               end
               void'(expected_counts.pop_front());
               counts_checked++;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d counts outstanding.",
                     WATCHDOG_LIMIT, expected_counts.size());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic queue_req(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] sym,
                            input logic [QLEN_W-1:0] qlen);
      hist_req_type rq;
      rq.action       = act;
      rq.symbol       = sym;
      rq.query_length = qlen;
      pending_reqs.push_back(rq);
   endtask

   task automatic wait_until_drained();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_counts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_run(input logic [CSR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid     <= 1'b0;
      model_min_run  = value;
   endtask

   initial begin
      logic [CSR_W-1:0]  phase_min_run[NUM_PHASES];
      logic [SYM_W-1:0]  alphabet[4];
      logic [SYM_W-1:0]  sym;
      logic [QLEN_W-1:0] qlen;
      int unsigned       pick, sel, len, queued;

      foreach (hist_model[i]) begin
         hist_model[i] = '0;
      end
      model_symbol  = '0;
      model_run_len = 0;
      model_min_run = hrh_pkg::MIN_RUN_RESET;
      phase_min_run = '{7'd1, 7'd0, 7'd2, 7'd64, 7'd127, 7'd3, 7'd65, 7'd4};
      phase_min_run[NUM_PHASES-1] = CSR_W'($urandom_range(10, 2));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset value of min_run.
      queue_req(hrh_pkg::ACT_READ, 8'h00, 7'd4);
      repeat (4) queue_req(hrh_pkg::ACT_SYMBOL, 8'h00, 7'd0);
      queue_req(hrh_pkg::ACT_READ, 8'h00, 7'd4);
      repeat (5) queue_req(hrh_pkg::ACT_SYMBOL, 8'hFF, 7'd127);
      queue_req(hrh_pkg::ACT_END, 8'h00, 7'd0);
      queue_req(hrh_pkg::ACT_END, 8'hFF, 7'd127);
      queue_req(ACT_UNUSED, 8'hAA, 7'h55);
      repeat (2) queue_req(hrh_pkg::ACT_SYMBOL, 8'h55, 7'h2A);
      queue_req(hrh_pkg::ACT_END, 8'h55, 7'd1);
      queue_req(hrh_pkg::ACT_READ, 8'h00, 7'd4);
      queue_req(hrh_pkg::ACT_READ, 8'hFF, 7'd5);
      queue_req(hrh_pkg::ACT_READ, 8'h55, 7'd2);
      queue_req(hrh_pkg::ACT_READ, 8'h00, 7'd0);
      queue_req(hrh_pkg::ACT_READ, 8'hFF, 7'd65);
      queue_req(hrh_pkg::ACT_READ, 8'hFF, 7'd127);
      queue_req(hrh_pkg::ACT_READ, 8'hFF, 7'd64);
      queue_req(hrh_pkg::ACT_READ, 8'hAA, 7'd1);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_until_drained();
         write_min_run(phase_min_run[phase]);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         foreach (alphabet[i]) begin
            alphabet[i] = SYM_W'($urandom);
         end
         queued = 0;
         while (queued < ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               sym = ($urandom_range(9) == 0) ? SYM_W'($urandom) : alphabet[$urandom_range(3)];
               sel = $urandom_range(99);
               if (sel < 80) begin
                  len = $urandom_range(6, 1);
               end else if (sel < 97) begin
                  len = $urandom_range(20, 7);
               end else begin
                  len = $urandom_range(80, 60);
               end
               repeat (len) queue_req(hrh_pkg::ACT_SYMBOL, sym, QLEN_W'($urandom));
               queued += len;
            end else if (pick < 55) begin
               queue_req(hrh_pkg::ACT_END, SYM_W'($urandom), QLEN_W'($urandom));
               queued++;
            end else if (pick < 95) begin
               sym = ($urandom_range(4) == 0) ? SYM_W'($urandom) : alphabet[$urandom_range(3)];
               sel = $urandom_range(99);
               if (sel < 75) begin
                  qlen = QLEN_W'($urandom_range(8, 1));
               end else if (sel < 92) begin
                  qlen = QLEN_W'($urandom_range(MAX_RUN, 1));
               end else if (sel < 96) begin
                  qlen = '0;
               end else begin
                  qlen = QLEN_W'($urandom_range(127, MAX_RUN + 1));
               end
               queue_req(hrh_pkg::ACT_READ, sym, qlen);
               queued++;
            end else begin
               queue_req(ACT_UNUSED, SYM_W'($urandom), QLEN_W'($urandom));
            end
         end
      end
      wait_until_drained();

      $display("Run covered %0d accepted requests and %0d checked bin counts", reqs_accepted,
               counts_checked);
      $display("over %0d min_run settings and four idle patterns; %0d mismatches.",
               NUM_PHASES + 1, mismatch_count);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/hrh_pkg.sv
rtl/core/hrh_hist_bank.sv
rtl/core/homopolymer_run_histogram_top.sv
test/homopolymer_run_histogram_top_tb.sv
